### src/xsed_pkg.sv
// Shared types and constants for the cross-reference stream entry decoder.
// Used by xsed_out_buf and xref_stream_entry_decoder_top; depends on nothing.
package xsed_pkg;

  // Fixed field widths of the stream and of the result.
  localparam int BYTE_W     = 8;
  localparam int ACC_W      = 32;
  localparam int OBJ_W      = 23;
  localparam int CNT_W      = 24;
  localparam int WREG_W     = 3;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TYPE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_WIDTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THIRD_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_OBJECT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OBJECT_COUNT = 3'd4;

  // Reset values of the width registers.
  localparam logic [WREG_W-1:0] TYPE_WIDTH_RST   = 3'd1;
  localparam logic [WREG_W-1:0] SECOND_WIDTH_RST = 3'd2;
  localparam logic [WREG_W-1:0] THIRD_WIDTH_RST  = 3'd1;

  // Entry kinds.
  localparam logic [KIND_W-1:0] KIND_FREE       = 2'd0;
  localparam logic [KIND_W-1:0] KIND_IN_USE     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_COMPRESSED = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNKNOWN    = 2'd3;

  // Type field values.
  localparam logic [ACC_W-1:0] TYPE_FREE       = 32'd0;
  localparam logic [ACC_W-1:0] TYPE_IN_USE     = 32'd1;
  localparam logic [ACC_W-1:0] TYPE_COMPRESSED = 32'd2;

  // One decoded entry.
  typedef struct packed {
    logic [OBJ_W-1:0]  object_number;
    logic [KIND_W-1:0] entry_kind;
    logic [ACC_W-1:0]  offset_or_index;
    logic [ACC_W-1:0]  generation;
    logic [ACC_W-1:0]  container_stream;
    logic              last_entry;
  } res_t;

endpackage

### src/xsed_out_buf.sv
// Result register with a skid stage for the entry decoder output channel.
// Depends on xsed_pkg for the result type.
module xsed_out_buf (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  xsed_pkg::res_t push_res,
  output logic          full,
  output logic          out_valid,
  input  logic          out_stall,
  output xsed_pkg::res_t out_res
);

  logic           skid_valid;
  xsed_pkg::res_t skid_res;
  logic           out_take;

  assign out_take = out_valid & ~out_stall;
  // The source must hold off while the skid stage is occupied.
  assign full = skid_valid;

  // Output register refills from the skid stage first, then from a new request.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (push) begin
        out_res <= push_res;
      end
    end else if (push) begin
      skid_res <= push_res;
    end
  end

endmodule

### src/xref_stream_entry_decoder_top.sv
// Top level of the cross-reference stream entry decoder.
// Depends on xsed_pkg and xsed_out_buf.
//
// The decoder takes one stream byte per clock cycle with no gaps of its own:
// each byte is shifted into the type, second or third field accumulator in the
// cycle it is accepted, and the byte that completes an entry registers the decoded
// result in the output register, or in the skid stage behind it while the output
// register is held. The skid stage lets input continue while a result waits;
// in_stall rises only when both the output register and the skid stage are
// held by a stalled output. Once object_count entries are done, further bytes
// are accepted and dropped. A write to any valid register index restarts the
// subsection; cfg_ready is always high.
module xref_stream_entry_decoder_top #(
  parameter int MAX_FIELD_BYTES = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  // Byte input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [xsed_pkg::BYTE_W-1:0]         data_byte,
  // Entry output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [xsed_pkg::OBJ_W-1:0]          object_number,
  output logic [xsed_pkg::KIND_W-1:0]         entry_kind,
  output logic [xsed_pkg::ACC_W-1:0]          offset_or_index,
  output logic [xsed_pkg::ACC_W-1:0]          generation,
  output logic [xsed_pkg::ACC_W-1:0]          container_stream,
  output logic                                last_entry,
  // Configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [xsed_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [xsed_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int FW    = $clog2(MAX_FIELD_BYTES + 1);
  localparam int POS_W = $clog2(3 * MAX_FIELD_BYTES + 1);

  // Configuration registers.
  logic [xsed_pkg::WREG_W-1:0] type_width;
  logic [xsed_pkg::WREG_W-1:0] second_width;
  logic [xsed_pkg::WREG_W-1:0] third_width;
  logic [xsed_pkg::OBJ_W-1:0]  first_object;
  logic [xsed_pkg::CNT_W-1:0]  object_count;

  // Progress through the subsection.
  logic [POS_W-1:0]           byte_position;
  logic [xsed_pkg::ACC_W-1:0] type_acc;
  logic                       type_ovf;
  logic [xsed_pkg::ACC_W-1:0] second_acc;
  logic [xsed_pkg::ACC_W-1:0] third_acc;
  logic [xsed_pkg::CNT_W-1:0] entries_done;

  logic [POS_W-1:0]           byte_position_next;
  logic [xsed_pkg::ACC_W-1:0] type_acc_next;
  logic                       type_ovf_next;
  logic [xsed_pkg::ACC_W-1:0] second_acc_next;
  logic [xsed_pkg::ACC_W-1:0] third_acc_next;

  logic [FW-1:0]    tw;
  logic [FW-1:0]    sw;
  logic [FW-1:0]    hw;
  logic [POS_W-1:0] tw_end;
  logic [POS_W-1:0] sw_end;
  logic [POS_W-1:0] total;

  logic                       accept;
  logic                       step;
  logic                       complete;
  logic                       cfg_write;
  logic                       cfg_known;
  logic [xsed_pkg::ACC_W-1:0] type_value;
  logic [xsed_pkg::CNT_W-1:0] done_inc;
  xsed_pkg::res_t             res;
  xsed_pkg::res_t             out_res;
  logic                       buf_full;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid & cfg_ready;
  assign cfg_known = cfg_index inside {xsed_pkg::REG_TYPE_WIDTH, xsed_pkg::REG_SECOND_WIDTH,
                                       xsed_pkg::REG_THIRD_WIDTH, xsed_pkg::REG_FIRST_OBJECT,
                                       xsed_pkg::REG_OBJECT_COUNT};

  assign in_stall = buf_full;
  assign accept   = in_valid & ~in_stall;
  assign step     = accept & (entries_done < object_count);

  // Field widths limited to the widest supported field.
  assign tw = (int'(type_width) > MAX_FIELD_BYTES) ? FW'(MAX_FIELD_BYTES) : FW'(type_width);
  assign sw = (int'(second_width) > MAX_FIELD_BYTES) ? FW'(MAX_FIELD_BYTES)
                                                     : FW'(second_width);
  assign hw = (int'(third_width) > MAX_FIELD_BYTES) ? FW'(MAX_FIELD_BYTES) : FW'(third_width);
  assign tw_end = POS_W'(tw);
  assign sw_end = tw_end + POS_W'(sw);
  assign total  = sw_end + POS_W'(hw);

  // Shift the byte into the field that owns the current position.
  always_comb begin
    type_acc_next      = type_acc;
    type_ovf_next      = type_ovf;
    second_acc_next    = second_acc;
    third_acc_next     = third_acc;
    byte_position_next = byte_position;
    complete           = 1'b0;
    if (total == '0) begin
      complete = 1'b1;
    end else begin
      if (byte_position < tw_end) begin
        type_ovf_next = type_ovf | (type_acc[xsed_pkg::ACC_W-1 -: xsed_pkg::BYTE_W] != '0);
        type_acc_next = {type_acc[xsed_pkg::ACC_W-xsed_pkg::BYTE_W-1:0], data_byte};
      end else if (byte_position < sw_end) begin
        second_acc_next = {second_acc[xsed_pkg::ACC_W-xsed_pkg::BYTE_W-1:0], data_byte};
      end else begin
        third_acc_next = {third_acc[xsed_pkg::ACC_W-xsed_pkg::BYTE_W-1:0], data_byte};
      end
      byte_position_next = byte_position + POS_W'(1);
      complete           = (byte_position_next >= total);
    end
  end

  // Decode the completed entry.
  assign type_value = (type_width == '0) ? xsed_pkg::TYPE_IN_USE : type_acc_next;
  assign done_inc   = entries_done + xsed_pkg::CNT_W'(1);

  always_comb begin
    res.object_number    = first_object + entries_done[xsed_pkg::OBJ_W-1:0];
    res.last_entry       = (done_inc == object_count);
    res.entry_kind       = xsed_pkg::KIND_UNKNOWN;
    res.offset_or_index  = '0;
    res.generation       = '0;
    res.container_stream = '0;
    if ((type_width != '0) && type_ovf_next) begin
      res.entry_kind = xsed_pkg::KIND_UNKNOWN;
    end else if (type_value == xsed_pkg::TYPE_FREE) begin
      res.entry_kind = xsed_pkg::KIND_FREE;
    end else if (type_value == xsed_pkg::TYPE_IN_USE) begin
      res.entry_kind      = xsed_pkg::KIND_IN_USE;
      res.offset_or_index = second_acc_next;
      res.generation      = third_acc_next;
    end else if (type_value == xsed_pkg::TYPE_COMPRESSED) begin
      res.entry_kind       = xsed_pkg::KIND_COMPRESSED;
      res.offset_or_index  = third_acc_next;
      res.container_stream = second_acc_next;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      type_width   <= xsed_pkg::TYPE_WIDTH_RST;
      second_width <= xsed_pkg::SECOND_WIDTH_RST;
      third_width  <= xsed_pkg::THIRD_WIDTH_RST;
      first_object <= '0;
      object_count <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        xsed_pkg::REG_TYPE_WIDTH: begin
          type_width <= cfg_data[xsed_pkg::WREG_W-1:0];
        end
        xsed_pkg::REG_SECOND_WIDTH: begin
          second_width <= cfg_data[xsed_pkg::WREG_W-1:0];
        end
        xsed_pkg::REG_THIRD_WIDTH: begin
          third_width <= cfg_data[xsed_pkg::WREG_W-1:0];
        end
        xsed_pkg::REG_FIRST_OBJECT: begin
          first_object <= cfg_data[xsed_pkg::OBJ_W-1:0];
        end
        xsed_pkg::REG_OBJECT_COUNT: begin
          object_count <= cfg_data[xsed_pkg::CNT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Entry progress: cleared by reset and by any known register write.
  always_ff @(posedge clk) begin
    if (rst || (cfg_write && cfg_known)) begin
      byte_position <= '0;
      type_acc      <= '0;
      type_ovf      <= 1'b0;
      second_acc    <= '0;
      third_acc     <= '0;
      entries_done  <= '0;
    end else if (step) begin
      if (complete) begin
        byte_position <= '0;
        type_acc      <= '0;
        type_ovf      <= 1'b0;
        second_acc    <= '0;
        third_acc     <= '0;
        entries_done  <= done_inc;
      end else begin
        byte_position <= byte_position_next;
        type_acc      <= type_acc_next;
        type_ovf      <= type_ovf_next;
        second_acc    <= second_acc_next;
        third_acc     <= third_acc_next;
      end
    end
  end

  // Result register and skid stage.
  xsed_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (step & complete),
    .push_res  (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign object_number    = out_res.object_number;
  assign entry_kind       = out_res.entry_kind;
  assign offset_or_index  = out_res.offset_or_index;
  assign generation       = out_res.generation;
  assign container_stream = out_res.container_stream;
  assign last_entry       = out_res.last_entry;

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the cross-reference stream entry decoder.
// Depends on xsed_pkg and xref_stream_entry_decoder_top; a built-in predictor
// checks every decoded entry across directed and random field layouts.
module tb_top;

  localparam int BYTE_W          = xsed_pkg::BYTE_W;
  localparam int ACC_W           = xsed_pkg::ACC_W;
  localparam int OBJ_W           = xsed_pkg::OBJ_W;
  localparam int CNT_W           = xsed_pkg::CNT_W;
  localparam int WREG_W          = xsed_pkg::WREG_W;
  localparam int KIND_W          = xsed_pkg::KIND_W;
  localparam int CFG_IDX_W       = xsed_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W      = xsed_pkg::CFG_DATA_W;
  localparam int MAX_FIELD_BYTES = 4;
  localparam int IDLE_PCT        = 26;
  localparam int SETTLE_CYCLES   = 4;
  localparam int RAND_BYTES      = 800;
  localparam int LIMIT_CYCLES    = 400000;
  localparam int CALM_START      = 300;
  localparam int CALM_BYTES      = 150;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO  = xsed_pkg::REG_OBJECT_COUNT + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI  = '1;
  localparam logic [OBJ_W-1:0]     OBJ_MAX        = '1;
  localparam logic [CNT_W-1:0]     CNT_HIGH       = 24'h800000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [BYTE_W-1:0]     data_byte = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [OBJ_W-1:0]      object_number;
  logic [KIND_W-1:0]     entry_kind;
  logic [ACC_W-1:0]      offset_or_index;
  logic [ACC_W-1:0]      generation;
  logic [ACC_W-1:0]      container_stream;
  logic                  last_entry;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  xref_stream_entry_decoder_top #(.MAX_FIELD_BYTES(MAX_FIELD_BYTES)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .data_byte(data_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .object_number(object_number), .entry_kind(entry_kind),
    .offset_or_index(offset_or_index), .generation(generation),
    .container_stream(container_stream), .last_entry(last_entry),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Pending stream bytes and the entries they are predicted to produce.
  logic [BYTE_W-1:0] byte_q[$];
  xsed_pkg::res_t    entry_q[$];
  int                errors = 0;
  int                entry_bytes = 0;
  int                cyc = 0;
  int                calm_from = -1;
  bit                calm = 1'b0;

  // Predictor copy of the registers and of the decode progress.
  logic [WREG_W-1:0] w_type   = xsed_pkg::TYPE_WIDTH_RST;
  logic [WREG_W-1:0] w_second = xsed_pkg::SECOND_WIDTH_RST;
  logic [WREG_W-1:0] w_third  = xsed_pkg::THIRD_WIDTH_RST;
  logic [OBJ_W-1:0]  first_obj = '0;
  logic [CNT_W-1:0]  obj_count = '0;
  int                byte_pos = 0;
  logic [ACC_W-1:0]  acc_type = '0;
  logic [ACC_W-1:0]  acc_second = '0;
  logic [ACC_W-1:0]  acc_third = '0;
  bit                type_ovf = 1'b0;
  logic [CNT_W-1:0]  entries_done = '0;

  function automatic int field_bytes(input logic [WREG_W-1:0] w);
    return (w > MAX_FIELD_BYTES) ? MAX_FIELD_BYTES : int'(w);
  endfunction

  // Append one byte to the pending stream.
  function automatic void queue_byte(input logic [BYTE_W-1:0] b);
    byte_q = {byte_q, b};
  endfunction

  function automatic void clear_progress();
    byte_pos     = 0;
    acc_type     = '0;
    acc_second   = '0;
    acc_third    = '0;
    type_ovf     = 1'b0;
    entries_done = '0;
  endfunction

  // Shift one byte into the current entry; returns 1 when an entry completes.
  function automatic bit decode_byte(input logic [BYTE_W-1:0] b,
                                     output xsed_pkg::res_t ent);
    int               tw;
    int               sw;
    int               hw;
    int               total;
    logic [ACC_W-1:0] tval;
    logic [CNT_W-1:0] next_done;
    tw    = field_bytes(w_type);
    sw    = field_bytes(w_second);
    hw    = field_bytes(w_third);
    total = tw + sw + hw;
    ent   = '0;
    if (entries_done >= obj_count) return 1'b0;
    // With all widths zero every byte completes an entry on its own.
    if (total != 0) begin
      if (byte_pos < tw) begin
        if (acc_type[31:24] != '0) type_ovf = 1'b1;
        acc_type = {acc_type[23:0], b};
      end else if (byte_pos < tw + sw) begin
        acc_second = {acc_second[23:0], b};
      end else begin
        acc_third = {acc_third[23:0], b};
      end
      byte_pos++;
      if (byte_pos < total) return 1'b0;
    end
    // A missing type field reads as in use; unknown types keep zero values.
    tval = (w_type == '0) ? xsed_pkg::TYPE_IN_USE : acc_type;
    ent.entry_kind = xsed_pkg::KIND_UNKNOWN;
    if (w_type == '0 || !type_ovf) begin
      if (tval == xsed_pkg::TYPE_FREE) begin
        ent.entry_kind = xsed_pkg::KIND_FREE;
      end else if (tval == xsed_pkg::TYPE_IN_USE) begin
        ent.entry_kind      = xsed_pkg::KIND_IN_USE;
        ent.offset_or_index = acc_second;
        ent.generation      = acc_third;
      end else if (tval == xsed_pkg::TYPE_COMPRESSED) begin
        ent.entry_kind       = xsed_pkg::KIND_COMPRESSED;
        ent.offset_or_index  = acc_third;
        ent.container_stream = acc_second;
      end
    end
    next_done         = entries_done + 1'b1;
    ent.object_number = first_obj + entries_done[OBJ_W-1:0];
    ent.last_entry    = (next_done == obj_count);
    clear_progress();
    entries_done = next_done;
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [ACC_W-1:0] want,
                                      input logic [ACC_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endfunction

  function automatic logic [ACC_W-1:0] pick_value();
    case ($urandom_range(3))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Cycle limit guards against a hung handshake.
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Byte driver: predicts each accepted request and presents the next one.
  always @(posedge clk) begin : drv
    xsed_pkg::res_t ent;
    bit             take;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      take = !in_valid;
      if (in_valid && !in_stall) begin
        if (decode_byte(data_byte, ent)) entry_q = {entry_q, ent};
        take = 1'b1;
      end
      if (take) begin
        if (byte_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid  <= 1'b1;
          data_byte <= byte_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Entry monitor: compares each accepted result with the oldest prediction.
  always @(posedge clk) begin : mon
    xsed_pkg::res_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (entry_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected entry, expected none, actual object 0x%0h", $time,
                   object_number);
        end else begin
          want = entry_q.pop_front();
          check_field("object_number", ACC_W'(want.object_number), ACC_W'(object_number));
          check_field("entry_kind", ACC_W'(want.entry_kind), ACC_W'(entry_kind));
          check_field("offset_or_index", want.offset_or_index, offset_or_index);
          check_field("generation", want.generation, generation);
          check_field("container_stream", want.container_stream, container_stream);
          check_field("last_entry", ACC_W'(want.last_entry), ACC_W'(last_entry));
        end
      end
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Wait until no byte is pending and no entry is outstanding, then settle.
  task automatic wait_idle();
    do @(negedge clk); while (byte_q.size() != 0 || in_valid || entry_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write request; called in a rising-edge time step.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      xsed_pkg::REG_TYPE_WIDTH:   w_type    = val[WREG_W-1:0];
      xsed_pkg::REG_SECOND_WIDTH: w_second  = val[WREG_W-1:0];
      xsed_pkg::REG_THIRD_WIDTH:  w_third   = val[WREG_W-1:0];
      xsed_pkg::REG_FIRST_OBJECT: first_obj = val[OBJ_W-1:0];
      xsed_pkg::REG_OBJECT_COUNT: obj_count = val[CNT_W-1:0];
      default:                    return;
    endcase
    clear_progress();
  endtask

  // Start a new subsection with the given field layout.
  task automatic set_layout(input logic [WREG_W-1:0] tw, sw, hw,
                            input logic [OBJ_W-1:0] first, input logic [CNT_W-1:0] count);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    wait_idle();
    cfg_write(xsed_pkg::REG_TYPE_WIDTH, {junk[23:3], tw});
    cfg_write(xsed_pkg::REG_SECOND_WIDTH, {junk[22:2], sw});
    cfg_write(xsed_pkg::REG_THIRD_WIDTH, {junk[21:1], hw});
    cfg_write(xsed_pkg::REG_FIRST_OBJECT, {junk[23], first});
    cfg_write(xsed_pkg::REG_OBJECT_COUNT, count);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // A write to an unused index must leave the partial entry untouched.
  task automatic write_unused_reg();
    wait_idle();
    cfg_write(CFG_IDX_W'($urandom_range(REG_UNUSED_HI, REG_UNUSED_LO)),
              CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic push_field(input logic [ACC_W-1:0] val, input int n);
    for (int i = n - 1; i >= 0; i--) queue_byte(val[8*i +: 8]);
  endtask

  // Queue one well-formed entry, big-endian, in the current layout.
  task automatic push_entry(input logic [ACC_W-1:0] t, s, h);
    int tw;
    int sw;
    int hw;
    tw = field_bytes(w_type);
    sw = field_bytes(w_second);
    hw = field_bytes(w_third);
    if (tw + sw + hw == 0) begin
      queue_byte(BYTE_W'($urandom));
      entry_bytes++;
    end else begin
      push_field(t, tw);
      push_field(s, sw);
      push_field(h, hw);
      entry_bytes += tw + sw + hw;
    end
  endtask

  initial begin
    logic [WREG_W-1:0] ws[3];
    logic [CNT_W-1:0]  count;
    logic [OBJ_W-1:0]  first;
    logic [ACC_W-1:0]  t;
    int                n;
    int                r;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Out of reset the count is zero, so these bytes are dropped.
    queue_byte(8'h00);
    queue_byte(8'hFF);

    // One entry of every kind, an unknown type, and a byte past the count.
    set_layout(3'd1, 3'd1, 3'd1, '0, 24'd4);
    push_entry(xsed_pkg::TYPE_FREE, 32'hFF, 32'hFF);
    push_entry(xsed_pkg::TYPE_IN_USE, 32'hFF, 32'hFF);
    push_entry(xsed_pkg::TYPE_COMPRESSED, 32'h00, 32'h80);
    push_entry(32'hFF, 32'h12, 32'h34);
    queue_byte(8'hAA);

    // No fields at all: each byte is an entry; object numbers wrap.
    set_layout(3'd0, 3'd0, 3'd0, OBJ_MAX, 24'd3);
    repeat (3) push_entry('0, '0, '0);
    queue_byte(8'h55);

    // Oversized width register clamps to four type bytes.
    set_layout(3'd7, 3'd0, 3'd0, 23'd5, 24'd2);
    push_entry(32'h80000001, '0, '0);
    push_entry(xsed_pkg::TYPE_COMPRESSED, '0, '0);

    // Missing type field with full-width offset and generation.
    set_layout(3'd0, 3'd4, 3'd4, OBJ_MAX, CNT_HIGH);
    push_entry('0, '1, '1);

    // Unused register index in the middle of an entry.
    set_layout(3'd1, 3'd1, 3'd1, '0, 24'd1);
    queue_byte(xsed_pkg::TYPE_IN_USE[7:0]);
    queue_byte(8'h5A);
    write_unused_reg();
    queue_byte(8'hC3);

    // Random layouts with mostly well-formed entries and some noise.
    entry_bytes = 0;
    while (entry_bytes < RAND_BYTES) begin
      foreach (ws[i]) ws[i] = ($urandom_range(9) == 0) ? WREG_W'($urandom_range(7, 5)) :
                              WREG_W'($urandom_range(MAX_FIELD_BYTES));
      r = $urandom_range(19);
      if (r == 0) count = '0;
      else if (r == 1) count = CNT_W'($urandom);
      else count = CNT_W'($urandom_range(24, 1));
      first = ($urandom_range(7) == 0) ? OBJ_MAX : OBJ_W'($urandom);
      set_layout(ws[0], ws[1], ws[2], first, count);
      // One stretch of layouts runs with no idling on either side.
      if (calm_from < 0 && entry_bytes >= CALM_START) calm_from = entry_bytes;
      calm = (calm_from >= 0) && (entry_bytes < calm_from + CALM_BYTES);
      n = (count < 24) ? int'(count) : 24;
      for (int e = 0; e < n; e++) begin
        if ($urandom_range(19) == 0) queue_byte(BYTE_W'($urandom));
        if (e == n / 2 && $urandom_range(7) == 0) write_unused_reg();
        case ($urandom_range(9))
          0, 1, 2: t = xsed_pkg::TYPE_FREE;
          3, 4, 5: t = xsed_pkg::TYPE_IN_USE;
          6, 7:    t = xsed_pkg::TYPE_COMPRESSED;
          default: t = $urandom;
        endcase
        push_entry(t, pick_value(), pick_value());
      end
      repeat ($urandom_range(2)) queue_byte(BYTE_W'($urandom));
      if (count == '0) repeat (3) queue_byte(BYTE_W'($urandom));
    end

    wait_idle();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
